/* rtl/bdasc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the box downscale to ASCII ramp unit.
// No dependencies; every other file in rtl/ imports this package.
package bdasc_pkg;

   localparam int DEF_MAX_SRC_DIM   = 4096;
   localparam int DEF_MAX_OUT_WIDTH = 4096;

   localparam int CSR_W      = 13;   // width of each config register
   localparam int CSR_ADDR_W = 2;
   localparam int PIX_W      = 8;
   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 2;
   localparam int QUEUE_DEPTH = 4;

   // config register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_WIDTH  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

   // brightness ramp, darkest first
   localparam int RAMP_LEVELS = 16;
   localparam logic [CHAR_W-1:0] RAMP_TABLE [RAMP_LEVELS] = '{
      8'h2E, 8'h2C, 8'h2D, 8'h7E, 8'h3A, 8'h3B, 8'h3F, 8'h2A,
      8'h2B, 8'h53, 8'h58, 8'h73, 8'h78, 8'h25, 8'h23, 8'h40
   };

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_GEO_START,
      ST_GEO_OH,
      ST_GEO_COL,
      ST_GEO_ROW,
      ST_CLEAR,
      ST_PIX_RD,
      ST_PIX_ADD,
      ST_CELL_DIV,
      ST_EMIT_CHAR,
      ST_EMIT_NL,
      ST_ADV
   } state_type;

   typedef struct packed {
      logic              scale_error;
      logic              frame_done;
      logic              last;
      logic [CHAR_W-1:0] char_code;
   } result_type;

   // avg in 0..255 -> ramp character; floor(avg*15/255) = floor(avg/17),
   // done as avg*241 >> 12, exact over 0..255
   function automatic logic [CHAR_W-1:0] ramp_char(input logic [PIX_W-1:0] avg);
      logic [15:0] scaled;
      scaled = 16'(avg) * 16'd241;
      return RAMP_TABLE[scaled[15:12]];
   endfunction

endpackage

/* rtl/bdasc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts pixels, clamps the geometry registers and classifies
// each transfer as pixel, frame start or scale error. Uses bdasc_pkg.
module bdasc_front import bdasc_pkg::*; #(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int DIM_W = $clog2(MAX_SRC_DIM + 1),
   parameter int NW_W  = $clog2(MAX_OUT_WIDTH + 1),
   parameter int ENT_W = PIX_W + KIND_W + 2 * DIM_W + NW_W
) (
   input  logic [CSR_W-1:0] src_width,
   input  logic [CSR_W-1:0] src_height,
   input  logic [CSR_W-1:0] out_width,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] req_tdata,
   input  logic             req_tuser,
   input  logic             q_full,
   output logic             push_valid,
   output logic [ENT_W-1:0] push_data
);

   localparam int XW = CSR_W + DIM_W + NW_W;

   logic [XW-1:0]    w_x, h_x, ow_x, nw_x;
   logic             err;
   kind_type         kind;

   function automatic logic [XW-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      logic [XW-1:0] r;
      r = XW'(v);
      if (r == '0) r = XW'(1);
      if (r > XW'(MAX_SRC_DIM)) r = XW'(MAX_SRC_DIM);
      return r;
   endfunction

   always_comb begin
      w_x  = clamp_dim(src_width);
      h_x  = clamp_dim(src_height);
      ow_x = (XW'(out_width) > XW'(MAX_OUT_WIDTH)) ? XW'(MAX_OUT_WIDTH) : XW'(out_width);
      err  = ow_x > w_x;
      nw_x = (ow_x == '0) ? w_x : ow_x;
      if (nw_x > XW'(MAX_OUT_WIDTH)) nw_x = XW'(MAX_OUT_WIDTH);
      priority if (err) begin
         kind = KIND_ERROR;
      end else if (req_tuser) begin
         kind = KIND_FRAME;
      end else begin
         kind = KIND_PIXEL;
      end
   end

   assign req_tready = !q_full;
   assign push_valid = req_tvalid && !q_full;
   assign push_data  = {nw_x[NW_W-1:0], h_x[DIM_W-1:0], w_x[DIM_W-1:0], kind, req_tdata};

endmodule

/* rtl/bdasc_queue.sv */
`timescale 1ns / 1ps
// Small FIFO between front and back end.
// Uses bdasc_pkg for the depth.
module bdasc_queue import bdasc_pkg::*; #(
   parameter int ENT_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [ENT_W-1:0] push_data,
   output logic             q_full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [ENT_W-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ENT_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = CNT_W'(count_ff + 1'b1);
      if (do_pop && !do_push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* rtl/bdasc_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Uses bdasc_pkg for default sizes.
module bdasc_div import bdasc_pkg::*; #(
   parameter int DVD_W = 2 * $clog2(DEF_MAX_SRC_DIM + 1) + 8,
   parameter int DVS_W = 2 * $clog2(DEF_MAX_SRC_DIM + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] q_ff;
   logic [DVS_W-1:0] r_ff, d_ff, r_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] trial;
   logic             ge;

   always_comb begin
      shifted = {r_ff, q_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, d_ff};
      ge      = !trial[DVS_W+1];
      r_in    = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= CNT_W'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[DVD_W-2:0], ge};
         r_ff <= r_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

/* rtl/bdasc_back.sv */
`timescale 1ns / 1ps
// Back end: frame geometry setup, column sum memory, cell averaging and
// result output register. Uses bdasc_pkg and bdasc_div.
module bdasc_back import bdasc_pkg::*; #(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
   parameter int DIM_W = $clog2(MAX_SRC_DIM + 1),
   parameter int NW_W  = $clog2(MAX_OUT_WIDTH + 1),
   parameter int ENT_W = PIX_W + KIND_W + 2 * DIM_W + NW_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  logic [ENT_W-1:0]  pop_data,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output result_type        rsp_result
);

   localparam int COL_W = $clog2(MAX_OUT_WIDTH);
   localparam int DVS_W = 2 * DIM_W;
   localparam int SUM_W = 2 * DIM_W + 8;
   localparam int DVD_W = SUM_W;

   // queue entry fields
   logic [PIX_W-1:0] e_pixel;
   kind_type         e_kind;
   logic [DIM_W-1:0] e_w, e_h;
   logic [NW_W-1:0]  e_nw;

   assign e_pixel = pop_data[PIX_W-1:0];
   assign e_kind  = kind_type'(pop_data[PIX_W +: KIND_W]);
   assign e_w     = pop_data[PIX_W + KIND_W +: DIM_W];
   assign e_h     = pop_data[PIX_W + KIND_W + DIM_W +: DIM_W];
   assign e_nw    = pop_data[PIX_W + KIND_W + 2 * DIM_W +: NW_W];

   state_type        state_ff, state_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [DIM_W-1:0] lat_w_ff, lat_w_in, lat_h_ff, lat_h_in, oh_ff, oh_in;
   logic [NW_W-1:0]  lat_nw_ff, lat_nw_in;
   logic [DIM_W-1:0] in_col_ff, in_col_in, in_row_ff, in_row_in, cell_row_ff, cell_row_in;
   logic [NW_W-1:0]  cell_col_ff, cell_col_in;
   logic [DIM_W-1:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [DIM_W-1:0] band_start_ff, band_start_in, band_end_ff, band_end_in;
   logic [DIM_W-1:0] cq_ff, cq_in, rq_ff, rq_in, rr_ff, rr_in, bandr_ff, bandr_in;
   logic [NW_W-1:0]  cr_ff, cr_in, colr_ff, colr_in, clr_ff, clr_in;
   logic [DVS_W-1:0] prod_ff, prod_in, area_ff, area_in;
   logic [PIX_W-1:0] avg_ff, avg_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // divider
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_quo;
   logic [DVS_W-1:0] div_dvs, div_rem;

   // column sum memory
   logic [SUM_W-1:0] sums_mem [MAX_OUT_WIDTH];
   logic [SUM_W-1:0] rd_data_ff, mem_wdata, sum_new;
   logic [COL_W-1:0] mem_waddr;
   logic             mem_we;

   logic             out_free, col_hit, band_hit, last_col, last_row;
   logic [NW_W:0]    c_sum;
   logic [DIM_W:0]   b_sum, row_next;
   logic             c_wrap, b_wrap;

   bdasc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) sums_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= sums_mem[cell_col_ff[COL_W-1:0]];
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      col_hit  = ({1'b0, in_col_ff} + 1'b1) == {1'b0, col_end_ff};
      band_hit = ({1'b0, in_row_ff} + 1'b1) == {1'b0, band_end_ff};
      last_col = ({1'b0, cell_col_ff} + 1'b1) == {1'b0, lat_nw_ff};
      last_row = ({1'b0, cell_row_ff} + 1'b1) == {1'b0, oh_ff};
      sum_new  = rd_data_ff + SUM_W'(pix_ff);
      c_sum    = {1'b0, colr_ff} + {1'b0, cr_ff};
      c_wrap   = c_sum >= {1'b0, lat_nw_ff};
      b_sum    = {1'b0, bandr_ff} + {1'b0, rr_ff};
      b_wrap   = b_sum >= {1'b0, oh_ff};
      row_next = {1'b0, in_row_ff} + 1'b1;

      state_in      = state_ff;
      pix_in        = pix_ff;
      lat_w_in      = lat_w_ff;
      lat_h_in      = lat_h_ff;
      lat_nw_in     = lat_nw_ff;
      oh_in         = oh_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      cell_col_in   = cell_col_ff;
      cell_row_in   = cell_row_ff;
      col_start_in  = col_start_ff;
      col_end_in    = col_end_ff;
      band_start_in = band_start_ff;
      band_end_in   = band_end_ff;
      cq_in         = cq_ff;
      cr_in         = cr_ff;
      rq_in         = rq_ff;
      rr_in         = rr_ff;
      colr_in       = colr_ff;
      bandr_in      = bandr_ff;
      clr_in        = clr_ff;
      prod_in       = prod_ff;
      area_in       = area_ff;
      avg_in        = avg_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      pop           = 1'b0;
      div_start     = 1'b0;
      div_dvd       = '0;
      div_dvs       = '0;
      mem_we        = 1'b0;
      mem_waddr     = cell_col_ff[COL_W-1:0];
      mem_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               pix_in = e_pixel;
               unique case (e_kind)
                  KIND_ERROR: state_in = ST_ERR;
                  KIND_FRAME: begin
                     lat_w_in  = e_w;
                     lat_h_in  = e_h;
                     lat_nw_in = e_nw;
                     prod_in   = DVS_W'(e_nw) * DVS_W'(e_h);
                     state_in  = ST_GEO_START;
                  end
                  KIND_PIXEL: begin
                     if (oh_ff == '0 || in_row_ff >= lat_h_ff || cell_col_ff >= lat_nw_ff) begin
                        state_in = ST_IDLE;
                     end else begin
                        state_in = ST_PIX_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_in       = '{scale_error: 1'b1, frame_done: 1'b0, last: 1'b1,
                                char_code: '0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_GEO_START: begin
            div_start = 1'b1;
            div_dvd   = (DVD_W'(prod_ff) << 3) + DVD_W'(prod_ff);
            div_dvs   = (DVS_W'(lat_w_ff) << 4) + (DVS_W'(lat_w_ff) << 2);
            state_in  = ST_GEO_OH;
         end
         ST_GEO_OH: begin
            if (div_done) begin
               oh_in = div_quo[DIM_W-1:0];
               if (div_quo[DIM_W-1:0] == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  div_dvd   = DVD_W'(lat_w_ff);
                  div_dvs   = DVS_W'(lat_nw_ff);
                  state_in  = ST_GEO_COL;
               end
            end
         end
         ST_GEO_COL: begin
            if (div_done) begin
               cq_in     = div_quo[DIM_W-1:0];
               cr_in     = div_rem[NW_W-1:0];
               div_start = 1'b1;
               div_dvd   = DVD_W'(lat_h_ff);
               div_dvs   = DVS_W'(oh_ff);
               state_in  = ST_GEO_ROW;
            end
         end
         ST_GEO_ROW: begin
            if (div_done) begin
               rq_in         = div_quo[DIM_W-1:0];
               rr_in         = div_rem[DIM_W-1:0];
               in_col_in     = '0;
               in_row_in     = '0;
               cell_col_in   = '0;
               cell_row_in   = '0;
               col_start_in  = '0;
               col_end_in    = cq_ff;
               colr_in       = cr_ff;
               band_start_in = '0;
               band_end_in   = div_quo[DIM_W-1:0];
               bandr_in      = div_rem[DIM_W-1:0];
               clr_in        = '0;
               state_in      = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[COL_W-1:0];
            if (({1'b0, clr_ff} + 1'b1) == {1'b0, lat_nw_ff}) begin
               state_in = ST_PIX_RD;
            end else begin
               clr_in = NW_W'(clr_ff + 1'b1);
            end
         end
         ST_PIX_RD: begin
            area_in  = DVS_W'(band_end_ff - band_start_ff) * DVS_W'(col_end_ff - col_start_ff);
            state_in = ST_PIX_ADD;
         end
         ST_PIX_ADD: begin
            mem_we = 1'b1;
            if (col_hit && band_hit) begin
               div_start = 1'b1;
               div_dvd   = sum_new;
               div_dvs   = area_ff;
               state_in  = ST_CELL_DIV;
            end else begin
               mem_wdata = sum_new;
               state_in  = ST_ADV;
            end
         end
         ST_CELL_DIV: begin
            if (div_done) begin
               avg_in   = div_quo[PIX_W-1:0];
               state_in = ST_EMIT_CHAR;
            end
         end
         ST_EMIT_CHAR: begin
            if (out_free) begin
               rsp_in       = '{scale_error: 1'b0, frame_done: 1'b0, last: !last_col,
                                char_code: ramp_char(avg_ff)};
               rsp_valid_in = 1'b1;
               state_in     = last_col ? ST_EMIT_NL : ST_ADV;
            end
         end
         ST_EMIT_NL: begin
            if (out_free) begin
               rsp_in       = '{scale_error: 1'b0, frame_done: last_row, last: 1'b1,
                                char_code: CHAR_NEWLINE};
               rsp_valid_in = 1'b1;
               state_in     = ST_ADV;
            end
         end
         ST_ADV: begin
            if (col_hit) begin
               if (!last_col) begin
                  cell_col_in  = NW_W'(cell_col_ff + 1'b1);
                  col_start_in = col_end_ff;
                  colr_in      = c_wrap ? NW_W'(c_sum - {1'b0, lat_nw_ff}) : NW_W'(c_sum);
                  col_end_in   = DIM_W'(col_end_ff + cq_ff + DIM_W'(c_wrap));
               end else begin
                  cell_col_in  = '0;
                  col_start_in = '0;
                  col_end_in   = cq_ff;
                  colr_in      = cr_ff;
               end
            end
            if (({1'b0, in_col_ff} + 1'b1) >= {1'b0, lat_w_ff}) begin
               in_col_in = '0;
               in_row_in = row_next[DIM_W-1:0];
               if (row_next == {1'b0, band_end_ff} && row_next < {1'b0, lat_h_ff}) begin
                  cell_row_in   = DIM_W'(cell_row_ff + 1'b1);
                  band_start_in = band_end_ff;
                  bandr_in      = b_wrap ? DIM_W'(b_sum - {1'b0, oh_ff}) : DIM_W'(b_sum);
                  band_end_in   = DIM_W'(band_end_ff + rq_ff + DIM_W'(b_wrap));
               end
            end else begin
               in_col_in = DIM_W'(in_col_ff + 1'b1);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         in_row_ff    <= '0;
         cell_col_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         oh_ff        <= oh_in;
         rsp_valid_ff <= rsp_valid_in;
         in_row_ff    <= in_row_in;
         cell_col_ff  <= cell_col_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff        <= pix_in;
      lat_w_ff      <= lat_w_in;
      lat_h_ff      <= lat_h_in;
      lat_nw_ff     <= lat_nw_in;
      in_col_ff     <= in_col_in;
      cell_row_ff   <= cell_row_in;
      col_start_ff  <= col_start_in;
      col_end_ff    <= col_end_in;
      band_start_ff <= band_start_in;
      band_end_ff   <= band_end_in;
      cq_ff         <= cq_in;
      cr_ff         <= cr_in;
      rq_ff         <= rq_in;
      rr_ff         <= rr_in;
      colr_ff       <= colr_in;
      bandr_ff      <= bandr_in;
      clr_ff        <= clr_in;
      prod_ff       <= prod_in;
      area_ff       <= area_in;
      avg_ff        <= avg_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

/* rtl/box_downscale_to_ascii_ramp_unit.sv */
`timescale 1ns / 1ps
// Box downscale to ASCII ramp, top level. Uses bdasc_pkg, front, queue, back.
// Back-end work: a pixel inside a cell goes through pop, memory read, add and
// write back, and counter update; a pixel closing a cell adds a divider run and
// the sending of each result. A frame start adds a multiply, three divisions and
// a clearing pass over the column sum memory that writes one entry per output
// column (up to MAX_OUT_WIDTH). A response waits on that work, and the queue
// registers every req transfer before the back end can pop it.
// Reset (synchronous): geometry registers return to 1, 1, 0; the block emits
// nothing but scale errors for pixels until a frame start is seen.
module box_downscale_to_ascii_ramp_unit import bdasc_pkg::*; #(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] frame_start
   // character stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_W-1:0]     rsp_tdata,   // [7:0] out_char
   output logic                  rsp_tlast,   // last_of_run
   output logic [1:0]            rsp_tuser,   // [0] frame_done, [1] scale_error
   // config writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int DIM_W = $clog2(MAX_SRC_DIM + 1);
   localparam int NW_W  = $clog2(MAX_OUT_WIDTH + 1);
   localparam int ENT_W = PIX_W + KIND_W + 2 * DIM_W + NW_W;

   // geometry registers; the user must change them only while the block is idle (not enforced)
   logic [CSR_W-1:0] src_width_ff, src_height_ff, out_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CSR_W'(1);
         src_height_ff <= CSR_W'(1);
         out_width_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   logic             q_full, push_valid, pop, pop_valid;
   logic [ENT_W-1:0] push_data, pop_data;
   result_type       rsp_result;

   // front: scale error check against the live registers, frame geometry
   // clamped and carried with each transfer so the back end never looks back
   bdasc_front #(
      .MAX_SRC_DIM  (MAX_SRC_DIM),
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
      .DIM_W        (DIM_W),
      .NW_W         (NW_W),
      .ENT_W        (ENT_W)
   ) u_front (
      .src_width (src_width_ff),
      .src_height(src_height_ff),
      .out_width (out_width_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .push_valid(push_valid),
      .push_data (push_data)
   );

   bdasc_queue #(.ENT_W(ENT_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .q_full    (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // back: per-column band sums, cell average via the shared divider,
   // ramp lookup and a one-deep output register
   bdasc_back #(
      .MAX_SRC_DIM  (MAX_SRC_DIM),
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
      .DIM_W        (DIM_W),
      .NW_W         (NW_W),
      .ENT_W        (ENT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_result(rsp_result)
   );

   assign rsp_tdata = rsp_result.char_code;
   assign rsp_tlast = rsp_result.last;
   assign rsp_tuser = {rsp_result.scale_error, rsp_result.frame_done};

endmodule

/* tb/box_downscale_to_ascii_ramp_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for box_downscale_to_ascii_ramp_unit: random pixel frames
// under several geometries, predicted characters compared transfer by transfer.
// Depends on bdasc_pkg and the RTL top level only.
module box_downscale_to_ascii_ramp_unit_test;
   import bdasc_pkg::*;

   localparam int MAX_DIM   = 4096;
   localparam int MAX_OW    = 4096;
   localparam int IDLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 5000;   // clearing pass plus divider, generous

   typedef struct packed {
      logic       frame_start;
      logic [7:0] pixel;
   } pixel_item;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid, rsp_tready;
   logic [CHAR_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic [1:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_W-1:0]      csr_wdata;

   box_downscale_to_ascii_ramp_unit dut (.*);

   // geometry registers as seen by the predictor
   int unsigned reg_w, reg_h, reg_ow;
   // frame state latched at frame start
   int unsigned fw, fh, fnw, oh;
   int unsigned px_col, px_row, c_col, c_row, c_start, c_end, b_start, b_end;
   longint unsigned col_sum [MAX_OW];

   pixel_item pending_pixels[$];
   result_type expected_chars[$];
   int unsigned mismatches, chars_seen, pixels_sent, idle_cycles;

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v == 0) v = 1;
      return v > MAX_DIM ? MAX_DIM : v;
   endfunction

   function automatic int unsigned col_edge(int unsigned k);
      return 32'((longint'(k) * fw) / fnw);
   endfunction

   function automatic int unsigned row_edge(int unsigned k);
      if (oh == 0) return fh;
      return 32'((longint'(k) * fh) / oh);
   endfunction

   task automatic latch_frame();
      int unsigned ow;
      fw = clamp_dim(reg_w);
      fh = clamp_dim(reg_h);
      ow = reg_ow > MAX_OW ? MAX_OW : reg_ow;
      fnw = (ow == 0) ? fw : ow;
      if (fnw > MAX_OW) fnw = MAX_OW;
      oh = 32'((longint'(fnw) * fh * 9) / (longint'(fw) * 20));
      px_col = 0; px_row = 0; c_col = 0; c_row = 0;
      c_start = 0; c_end = col_edge(1);
      b_start = 0; b_end = row_edge(1);
      foreach (col_sum[i]) col_sum[i] = 0;
   endtask

   // predicted characters for one accepted pixel
   task automatic predict_chars(pixel_item it);
      result_type r, q[$];
      int unsigned ow;
      longint unsigned area, avg, idx;
      ow = reg_ow > MAX_OW ? MAX_OW : reg_ow;
      if (ow > clamp_dim(reg_w)) begin
         r = '{scale_error: 1'b1, frame_done: 1'b0, last: 1'b1, char_code: '0};
         expected_chars.push_back(r);
         return;
      end
      if (it.frame_start) latch_frame();
      if (oh == 0 || px_row >= fh || c_col >= fnw) return;
      col_sum[c_col] += it.pixel;
      if (px_col + 1 == c_end) begin
         if (px_row + 1 == b_end) begin
            area = longint'(b_end - b_start) * (c_end - c_start);
            avg = area ? col_sum[c_col] / area : 0;
            idx = avg * (RAMP_LEVELS - 1) / 255;
            if (idx > RAMP_LEVELS - 1) idx = RAMP_LEVELS - 1;
            col_sum[c_col] = 0;
            r = '{scale_error: 1'b0, frame_done: 1'b0, last: 1'b0,
                  char_code: RAMP_TABLE[idx]};
            q.push_back(r);
            if (c_col + 1 == fnw) begin
               r.char_code = CHAR_NEWLINE;
               r.frame_done = (c_row + 1 == oh);
               q.push_back(r);
            end
            q[q.size()-1].last = 1'b1;
            foreach (q[i]) expected_chars.push_back(q[i]);
         end
         if (c_col + 1 < fnw) begin
            c_col++;
            c_start = c_end;
            c_end = col_edge(c_col + 1);
         end else begin
            c_col = 0; c_start = 0; c_end = col_edge(1);
         end
      end
      if (px_col + 1 >= fw) begin
         px_col = 0;
         px_row++;
         if (px_row == b_end && px_row < fh) begin
            c_row++;
            b_start = b_end;
            b_end = row_edge(c_row + 1);
         end
      end else begin
         px_col++;
      end
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH @%0t %s: got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   // mostly no gap, some short gaps, now and then a long one; a no-gap stretch in burst mode
   function automatic int unsigned gap_len(bit busy_phase);
      if (busy_phase) return 0;
      case ($urandom_range(0, 19))
         0:       return $urandom_range(20, 80);
         1, 2, 3: return $urandom_range(2, 6);
         4, 5, 6: return 1;
         default: return 0;
      endcase
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: one transfer per handshake, random gaps between
   int unsigned req_gap;
   bit burst_mode;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold
      end else begin
         if (req_tvalid) begin
            predict_chars({req_tuser, req_tdata});
            pixels_sent++;
         end
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            pixel_item it;
            it = pending_pixels.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= it.pixel;
            req_tuser <= it.frame_start;
            req_gap <= gap_len(burst_mode);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver-side stalls
   int unsigned rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_type want;
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.char_code)
                  report_mismatch("out_char", rsp_tdata, want.char_code);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_run", rsp_tlast, want.last);
               if (rsp_tuser[0] !== want.frame_done)
                  report_mismatch("frame_done", rsp_tuser[0], want.frame_done);
               if (rsp_tuser[1] !== want.scale_error)
                  report_mismatch("scale_error", rsp_tuser[1], want.scale_error);
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= gap_len(burst_mode);
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("box_downscale_to_ascii_ramp_unit test failed");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, int unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v[CSR_W-1:0];
      case (idx)
         CSR_SRC_WIDTH:  reg_w  = v & 13'h1FFF;
         CSR_SRC_HEIGHT: reg_h  = v & 13'h1FFF;
         CSR_OUT_WIDTH:  reg_ow = v & 13'h1FFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until everything queued has been sent and answered, then settle
   task automatic drain();
      wait (pending_pixels.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ow);
      write_csr(CSR_SRC_WIDTH, w);
      write_csr(CSR_SRC_HEIGHT, h);
      write_csr(CSR_OUT_WIDTH, ow);
   endtask

   // one frame of w*h pixels; style picks the pixel pattern
   task automatic queue_frame(int unsigned w, int unsigned h, int unsigned style);
      pixel_item it;
      for (int unsigned i = 0; i < w * h; i++) begin
         it.frame_start = (i == 0);
         case (style)
            0: it.pixel = 8'd0;
            1: it.pixel = 8'd255;
            default: it.pixel = $urandom_range(0, 255);
         endcase
         pending_pixels.push_back(it);
      end
   endtask

   task automatic queue_noise(int unsigned n);
      pixel_item it;
      for (int unsigned i = 0; i < n; i++) begin
         it.pixel = $urandom_range(0, 255);
         it.frame_start = 1'b0;
         pending_pixels.push_back(it);
      end
   endtask

   initial begin
      int unsigned w, h, ow, n;
      reg_w = 1; reg_h = 1; reg_ow = 0;
      latch_frame();
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      mismatches = 0; chars_seen = 0; pixels_sent = 0; idle_cycles = 0;
      burst_mode = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pixels before any frame start, reset geometry gives no rows
      queue_noise(3);
      drain();
      // 5x4 to 5 columns: 1 row; all-black then all-white frames
      set_geometry(5, 4, 0);
      queue_frame(5, 4, 0);
      queue_frame(5, 4, 1);
      queue_noise(2);               // past the end of the frame
      drain();
      // downscale with uneven cells
      set_geometry(7, 9, 3);
      queue_frame(7, 9, 2);
      drain();
      // out_width larger than src_width: every item an error
      set_geometry(2, 2, 3);
      queue_noise(2);
      queue_frame(1, 1, 1);
      drain();
      // zero sizes treated as 1, full 13-bit register values
      set_geometry(0, 0, 0);
      queue_frame(1, 3, 2);
      drain();
      set_geometry(8191, 8191, 8191);
      queue_noise(2);
      drain();
      // one pixel column, tall source
      set_geometry(1, 5, 1);
      queue_frame(1, 5, 2);
      drain();
      // widest output, one thin row: only a couple of pixels, no full frame
      set_geometry(4096, 3, 4096);
      queue_frame(1, 2, 1);
      drain();

      // random frames, mostly well formed; some cut short or run past the end
      while (pixels_sent < 950) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 14);
         ow = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, w);
         if ($urandom_range(0, 15) == 0) ow = w + 1;
         set_geometry(w, h, ow);
         burst_mode = ($urandom_range(0, 3) == 0);
         n = $urandom_range(1, 3);
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
               0: queue_noise($urandom_range(1, 6));
               1: queue_frame(w, h / 2 + 1, 2);          // broken frame
               default: queue_frame(w, h, 2);
            endcase
         end
         drain();
      end
      burst_mode = 0;

      $display("covered %0d pixels and %0d characters over directed and random geometries",
               pixels_sent, chars_seen);
      if (mismatches == 0) begin
         $display("box_downscale_to_ascii_ramp_unit test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("box_downscale_to_ascii_ramp_unit test failed");
      end
      $finish;
   end
endmodule
